FILE: rtl/mkd_pkg.sv
// Shared types and constants for the Morse key decoder core.
// No dependencies; imported by morse_keyer_decoder_core.
`default_nettype none

package mkd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MaxRes  = 6;
  localparam int unsigned ResCntW = 3;
  localparam int unsigned AddrW   = 5;

  // register indexes on the configuration port (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_SPLIT      = 3'd1,
    REG_CHAR_PAUSE = 3'd2,
    REG_CTRL_HOLD  = 3'd3,
    REG_AUTO_FLUSH = 3'd4
  } reg_idx_e;

  localparam logic [7:0]  DebounceRst  = 8'd8;
  localparam logic [15:0] SplitRst     = 16'd220;
  localparam logic [15:0] CharPauseRst = 16'd600;
  localparam logic [15:0] CtrlHoldRst  = 16'd500;
  localparam logic [15:0] AutoFlushRst = 16'd1500;

  localparam logic EvChar  = 1'b0;
  localparam logic EvFlush = 1'b1;

  localparam logic [6:0] AsciiSpace = 7'h20;
  localparam logic [6:0] AsciiQuery = 7'h3f;

  // binary tree, root at index 1: dot goes left (2i), dash goes right (2i+1)
  localparam logic [8*64-1:0] MorseTree =
    "??ETIANMSURWDKGOHVF?L?PJBXCYZQ??54?3???2???????16???????7???8?90";

  typedef struct packed {
    logic key_level;
    logic control_level;
  } mkd_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [6:0] char_code;
    logic       last_event;
  } mkd_out_t;

  typedef struct packed {
    logic             raw;
    logic             down;
    logic [TimeW-1:0] raw_time;
    logic             pressed;
    logic             released;
    logic [TimeW-1:0] edge_time;
  } deb_t;

  function automatic logic [6:0] tree_char(input logic [5:0] idx);
    logic [5:0] r;
    r = 6'd63 - idx;
    return MorseTree[{r, 3'b000} +: 7];
  endfunction

  // debounced level follows the raw level once it has held long enough;
  // the edge is stamped with the time of the raw change
  function automatic deb_t debounce(input logic sample, input logic raw,
                                    input logic down, input logic [TimeW-1:0] raw_time,
                                    input logic [TimeW-1:0] now, input logic [7:0] limit);
    deb_t d;
    d.raw       = raw;
    d.down      = down;
    d.raw_time  = raw_time;
    d.pressed   = 1'b0;
    d.released  = 1'b0;
    d.edge_time = '0;
    if (sample != raw) begin
      d.raw      = sample;
      d.raw_time = now;
    end
    if ((d.down != d.raw) && ((now - d.raw_time) >= TimeW'(limit))) begin
      d.down      = d.raw;
      d.edge_time = d.raw_time;
      d.pressed   = d.raw;
      d.released  = ~d.raw;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/morse_keyer_decoder_core.sv
// Straight-key Morse decoder core: one request per millisecond tick.
// Latency: a tick updates all state in the cycle it is accepted; its results
// (zero to four) leave from the next cycle on, one per cycle while taken.
// Throughput: one tick per cycle while each yields at most one result, taken
// at once; a tick waits only until the prior tick's last result is leaving.
// Reset: asynchronous; clears all but result data, loads register defaults.
// Depends on mkd_pkg.
`default_nettype none

module morse_keyer_decoder_core #(
  parameter int unsigned MARK_LIMIT = 6,
  parameter int unsigned WORD_LIMIT = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire mkd_pkg::mkd_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output mkd_pkg::mkd_out_t               out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mkd_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import mkd_pkg::*;

  localparam int unsigned McW = $clog2(MARK_LIMIT + 1);
  localparam int unsigned WcW = $clog2(WORD_LIMIT + 1);

  typedef struct packed {
    logic [WcW-1:0]             wc;
    logic [MARK_LIMIT-1:0]      mb;
    logic [McW-1:0]             mc;
    logic                       lettered;
    logic [ResCntW-1:0]         n;
    mkd_out_t [MaxRes-1:0]      ev;
  } acc_t;

  function automatic acc_t emit(input acc_t a, input logic kind, input logic [6:0] code);
    acc_t r;
    r = a;
    if (r.n < ResCntW'(MaxRes)) begin
      r.ev[r.n].event_kind = kind;
      r.ev[r.n].char_code  = code;
      r.ev[r.n].last_event = 1'b0;
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t flush_word(input acc_t a);
    acc_t r;
    r = a;
    if (r.wc != '0) begin
      r.wc = '0;
      r    = emit(r, EvFlush, 7'd0);
    end
    return r;
  endfunction

  function automatic acc_t append_char(input acc_t a, input logic [6:0] code);
    acc_t r;
    r = a;
    if (r.wc >= WcW'(WORD_LIMIT)) r = flush_word(r);
    r.wc       = r.wc + 1'b1;
    r.lettered = 1'b1;
    r          = emit(r, EvChar, code);
    if ((code == AsciiSpace) || (r.wc >= WcW'(WORD_LIMIT))) r = flush_word(r);
    return r;
  endfunction

  function automatic logic [6:0] decode_marks(input acc_t a);
    logic [5:0] idx;
    idx = 6'd1;
    if ((a.mc == '0) || (a.mc > McW'(5))) return AsciiQuery;
    for (int i = 0; i < 5; i++) begin
      if (i < int'(a.mc)) idx = {idx[4:0], a.mb[i]};
    end
    return tree_char(idx);
  endfunction

  function automatic acc_t finish_char(input acc_t a);
    acc_t       r;
    logic [6:0] c;
    r = a;
    if (r.mc != '0) begin
      c    = decode_marks(r);
      r.mb = '0;
      r.mc = '0;
      r    = append_char(r, c);
    end
    return r;
  endfunction

  // configuration registers
  logic [7:0]  debounce_q, debounce_d;
  logic [15:0] split_q, split_d, pause_q, pause_d, hold_q, hold_d, flush_q, flush_d;

  // decoder state
  logic [TimeW-1:0]      tick_q, kraw_t_q, kstart_q, craw_t_q, cstart_q, lmt_q, llt_q;
  logic [TimeW-1:0]      kraw_t_d, kstart_d, craw_t_d, cstart_d, lmt_d, llt_d;
  logic                  kraw_q, kdown_q, craw_q, cdown_q, chandled_q;
  logic                  kraw_d, kdown_d, craw_d, cdown_d, chandled_d;
  logic [MARK_LIMIT-1:0] mb_q;
  logic [McW-1:0]        mc_q;
  logic [WcW-1:0]        wc_q;

  // result buffer
  mkd_out_t [MaxRes-1:0] evq_q, evq_d;
  logic [ResCntW-1:0]    n_q, n_d, rd_q, rd_d;

  logic in_fire, out_fire, cfg_wr;
  deb_t kdeb, cdeb;
  acc_t acc;
  logic [TimeW-1:0] now, dur;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    debounce_d = debounce_q;
    split_d    = split_q;
    pause_d    = pause_q;
    hold_d     = hold_q;
    flush_d    = flush_q;
    prdata     = '0;
    unique case (paddr[4:2])
      REG_DEBOUNCE: begin
        prdata = 32'(debounce_q);
        if (cfg_wr) debounce_d = pwdata[7:0];
      end
      REG_SPLIT: begin
        prdata = 32'(split_q);
        if (cfg_wr) split_d = pwdata[15:0];
      end
      REG_CHAR_PAUSE: begin
        prdata = 32'(pause_q);
        if (cfg_wr) pause_d = pwdata[15:0];
      end
      REG_CTRL_HOLD: begin
        prdata = 32'(hold_q);
        if (cfg_wr) hold_d = pwdata[15:0];
      end
      REG_AUTO_FLUSH: begin
        prdata = 32'(flush_q);
        if (cfg_wr) flush_d = pwdata[15:0];
      end
      default: prdata = '0;
    endcase
  end

  // a new tick may enter as the last pending result leaves
  assign out_valid_o = (rd_q != n_q);
  assign in_ready_o  = (rd_q == n_q) || (((rd_q + 1'b1) == n_q) && out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;
  assign out_data_o  = evq_q[rd_q];

  assign now = tick_q;

  always_comb begin
    kdeb = debounce(in_data_i.key_level, kraw_q, kdown_q, kraw_t_q, now, debounce_q);
    cdeb = debounce(in_data_i.control_level, craw_q, cdown_q, craw_t_q, now, debounce_q);

    kraw_d   = kdeb.raw;
    kdown_d  = kdeb.down;
    kraw_t_d = kdeb.raw_time;
    craw_d   = cdeb.raw;
    cdown_d  = cdeb.down;
    craw_t_d = cdeb.raw_time;

    acc          = '0;
    acc.wc       = wc_q;
    acc.mb       = mb_q;
    acc.mc       = mc_q;
    kstart_d     = kstart_q;
    lmt_d        = lmt_q;
    cstart_d     = cstart_q;
    chandled_d   = chandled_q;
    dur          = kdeb.edge_time - kstart_q;

    if (kdeb.pressed) begin
      // a new press after a long gap closes the pending character first
      if ((acc.mc != '0) && ((kdeb.edge_time - lmt_q) >= TimeW'(pause_q)))
        acc = finish_char(acc);
      kstart_d = kdeb.edge_time;
    end
    if (kdeb.released) begin
      if (acc.mc < McW'(MARK_LIMIT)) begin
        if (dur >= TimeW'(split_q))
          acc.mb = acc.mb | (MARK_LIMIT'(1) << acc.mc);
        acc.mc = acc.mc + 1'b1;
      end
      lmt_d = kdeb.edge_time;
    end
    if (cdeb.pressed) begin
      cstart_d   = cdeb.edge_time;
      chandled_d = 1'b0;
    end
    if (cdown_d && !chandled_d && ((now - cstart_d) >= TimeW'(hold_q))) begin
      chandled_d = 1'b1;
      acc        = finish_char(acc);
      acc        = append_char(acc, AsciiSpace);
    end
    if (cdeb.released && !chandled_d) begin
      acc = finish_char(acc);
      acc = flush_word(acc);
    end
    if (!kdown_d && !kraw_d && (acc.mc != '0) && ((now - lmt_d) >= TimeW'(pause_q)))
      acc = finish_char(acc);
    llt_d = acc.lettered ? now : llt_q;
    if ((acc.wc != '0) && ((now - llt_d) >= TimeW'(flush_q)))
      acc = flush_word(acc);

    evq_d = acc.ev;
    if (acc.n != '0) evq_d[acc.n - 1'b1].last_event = 1'b1;
    n_d  = acc.n;
    rd_d = rd_q;
    if (in_fire) rd_d = '0;
    else if (out_fire) rd_d = rd_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      split_q    <= SplitRst;
      pause_q    <= CharPauseRst;
      hold_q     <= CtrlHoldRst;
      flush_q    <= AutoFlushRst;
      tick_q     <= '0;
      kraw_q     <= 1'b0;
      kdown_q    <= 1'b0;
      kraw_t_q   <= '0;
      kstart_q   <= '0;
      craw_q     <= 1'b0;
      cdown_q    <= 1'b0;
      craw_t_q   <= '0;
      cstart_q   <= '0;
      chandled_q <= 1'b0;
      mb_q       <= '0;
      mc_q       <= '0;
      lmt_q      <= '0;
      llt_q      <= '0;
      wc_q       <= '0;
      n_q        <= '0;
      rd_q       <= '0;
    end else begin
      debounce_q <= debounce_d;
      split_q    <= split_d;
      pause_q    <= pause_d;
      hold_q     <= hold_d;
      flush_q    <= flush_d;
      rd_q       <= rd_d;
      if (in_fire) begin
        tick_q     <= tick_q + 1'b1;
        kraw_q     <= kraw_d;
        kdown_q    <= kdown_d;
        kraw_t_q   <= kraw_t_d;
        kstart_q   <= kstart_d;
        craw_q     <= craw_d;
        cdown_q    <= cdown_d;
        craw_t_q   <= craw_t_d;
        cstart_q   <= cstart_d;
        chandled_q <= chandled_d;
        mb_q       <= acc.mb;
        mc_q       <= acc.mc;
        lmt_q      <= lmt_d;
        llt_q      <= llt_d;
        wc_q       <= acc.wc;
        n_q        <= n_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) evq_q <= evq_d;
  end

`ifndef NO_ASSERTIONS
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_q <= n_q) && (n_q <= ResCntW'(MaxRes)))
    else $error("result read index beyond buffered count");

  a_overlap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_o) |-> (out_ready_i && out_data_o.last_event))
    else $error("new tick accepted while results still pending");

  a_word_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q < WcW'(WORD_LIMIT))
    else $error("word count reached limit without flush");

  a_marks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mc_q <= McW'(MARK_LIMIT))
    else $error("mark count exceeds buffer");

  a_flush_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_kind == EvFlush)) |-> (out_data_o.char_code == 7'd0))
    else $error("flush request carries a character code");
`endif

endmodule

`default_nettype wire
